// ===== rtl/sfv_pkg.sv =====
// ----------------------------------------------------------------------------
// sfv_pkg
// types and constants shared by the spray flow valve controller
// ----------------------------------------------------------------------------
package sfv_pkg;

  localparam int HighBankBase = 5;
  localparam int ValveBits    = 16;
  localparam int HighMax      = (HighBankBase < ValveBits) ? ValveBits - HighBankBase : 0;
  localparam int LowMax       = (HighBankBase < ValveBits) ? HighBankBase : ValveBits;

  // reciprocal multipliers: x / 10000 = (x * Div10kMul) >> 45 for x below 2^32,
  // x / 100 = (x * Div100Mul) >> 32 for x below 2^26
  localparam logic [31:0] Div10kMul = 32'd3518437209;
  localparam logic [25:0] Div100Mul = 26'd42949673;

  typedef enum logic [2:0] {
    REG_BOOM_WIDTH  = 3'd0,
    REG_WATER_AREA  = 3'd1,
    REG_HIGH_RATE   = 3'd2,
    REG_LOW_RATE    = 3'd3,
    REG_HIGH_TOTAL  = 3'd4,
    REG_LOW_TOTAL   = 3'd5,
    REG_MIN_PULSE   = 3'd6,
    REG_MANUAL_RATE = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [23:0] pulse_count;
    logic [23:0] elapsed_ms;
    logic        manual_mode;
  } in_item_t;

  typedef struct packed {
    logic [25:0] coverage_speed;
    logic [31:0] flow_demand;
    logic [3:0]  high_open;
    logic [2:0]  low_open;
    logic [15:0] valve_map;
    logic        pump_running;
    logic        pump_toggled;
  } out_item_t;

  typedef struct packed {
    logic [15:0] boom_width_mm;
    logic [15:0] water_per_area;
    logic [15:0] high_valve_rate;
    logic [15:0] low_valve_rate;
    logic [3:0]  high_valve_total;
    logic [2:0]  low_valve_total;
    logic [15:0] min_pulse_rate;
    logic [31:0] manual_rate;
  } cfg_t;

  // classified item between front and back
  typedef struct packed {
    logic [25:0] speed;
    logic [31:0] flow;
  } job_t;

endpackage

// ===== rtl/sfv_div.sv =====
// ----------------------------------------------------------------------------
// sfv_div
// restoring divider, one quotient bit per cycle, 48 by 24 bits
// ----------------------------------------------------------------------------
module sfv_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] num_i,
  input  logic [23:0] den_i,
  output logic        done_o,
  output logic [47:0] quot_o
);

  logic [47:0] quot_q, quot_d;
  logic [24:0] rem_q, rem_d;
  logic [23:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [24:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[23:0], quot_q[47]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 6'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[46:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[46:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd47) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/sfv_front.sv =====
// ----------------------------------------------------------------------------
// sfv_front
// accepts periods, works out coverage speed and flow demand
// ----------------------------------------------------------------------------
module sfv_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfv_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sfv_pkg::in_item_t in_item_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output sfv_pkg::job_t     job_o
);

  typedef enum logic [10:0] {
    F_IDLE  = 11'b00000000001,
    F_RATE  = 11'b00000000010,
    F_WIDTH = 11'b00000000100,
    F_SCALE = 11'b00000001000,
    F_CLAMP = 11'b00000010000,
    F_FLOW  = 11'b00000100000,
    F_FDIV  = 11'b00001000000,
    F_CENT  = 11'b00010000000,
    F_PART  = 11'b00100000000,
    F_SUM   = 11'b01000000000,
    F_OUT   = 11'b10000000000
  } fstate_e;

  fstate_e     st_q, st_d;
  logic [23:0] pc_q, el_q;
  logic [47:0] acc_q, acc_d;
  logic [25:0] speed_q, speed_d;
  logic [31:0] flow_q, flow_d;
  logic [18:0] cq_q, cq_d;
  logic [22:0] rw_q, rw_d;
  logic        div_start;
  logic [47:0] div_num;
  logic [23:0] div_den;
  logic        div_done;
  logic [47:0] div_quot;
  logic [15:0] dz;
  logic [15:0] pcl;
  logic [31:0] mr;
  logic [63:0] sc_prod;
  logic [51:0] ce_prod;
  logic [6:0]  rem;
  logic [48:0] rw_prod;
  logic [36:0] total;

  sfv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign dz  = (cfg_i.min_pulse_rate == 16'd0) ? 16'd1000 : cfg_i.min_pulse_rate;
  assign pcl = (pc_q > 24'hffff) ? 16'hffff : pc_q[15:0];
  assign mr  = cfg_i.manual_rate;

  // divide by 10000 and by 100 through reciprocal multiplication
  assign sc_prod = 64'(acc_q[31:0]) * 64'(sfv_pkg::Div10kMul);
  assign ce_prod = 52'(speed_q) * 52'(sfv_pkg::Div100Mul);
  assign rem     = 7'(speed_q - 26'(cq_q) * 26'd100);
  assign rw_prod = 49'(rw_q) * 49'(sfv_pkg::Div100Mul);
  assign total   = 37'(acc_q[34:0]) + 37'(rw_prod[48:32]);

  always_comb begin
    st_d      = st_q;
    acc_d     = acc_q;
    speed_d   = speed_q;
    flow_d    = flow_q;
    cq_d      = cq_q;
    rw_d      = rw_q;
    div_start = 1'b0;
    div_num   = acc_q;
    div_den   = el_q;
    case (st_q)
      F_IDLE: begin
        if (in_valid_i) begin
          speed_d = '0;
          if (in_item_i.manual_mode) begin
            if (mr == 32'd0) flow_d = 32'd100000;
            else if (mr == 32'hffffffff) flow_d = '0;
            else flow_d = mr;
            st_d = F_OUT;
          end else if (in_item_i.elapsed_ms < 24'd100 || in_item_i.pulse_count == 24'd0) begin
            flow_d = '0;
            st_d   = F_OUT;
          end else begin
            st_d = F_RATE;
          end
        end
      end
      F_RATE: begin
        // pulse rate per minute against the dead zone
        div_start = 1'b1;
        div_num   = 48'(pc_q) * 48'd60000;
        st_d      = F_WIDTH;
      end
      F_WIDTH: begin
        if (div_done) begin
          if (div_quot < 48'(dz)) begin
            flow_d = '0;
            st_d   = F_OUT;
          end else begin
            acc_d = 48'(32'(pcl) * 32'(cfg_i.boom_width_mm));
            st_d  = F_SCALE;
          end
        end
      end
      F_SCALE: begin
        if (sc_prod[63:45] > 19'h0ffff) acc_d = 48'hffff;
        else acc_d = 48'(sc_prod[63:45]);
        st_d = F_CLAMP;
      end
      F_CLAMP: begin
        acc_d = 48'(32'(acc_q[15:0]) * 32'd60000);
        st_d  = F_FLOW;
      end
      F_FLOW: begin
        div_start = 1'b1;
        st_d      = F_FDIV;
      end
      F_FDIV: begin
        if (div_done) begin
          speed_d = div_quot[25:0];
          st_d    = F_CENT;
        end
      end
      F_CENT: begin
        // speed split into hundreds and remainder keeps the products narrow
        cq_d = ce_prod[50:32];
        st_d = F_PART;
      end
      F_PART: begin
        acc_d = 48'(35'(cq_q) * 35'(cfg_i.water_per_area));
        rw_d  = 23'(rem) * 23'(cfg_i.water_per_area);
        st_d  = F_SUM;
      end
      F_SUM: begin
        if (total > 37'h0ffffffff) flow_d = 32'hffffffff;
        else flow_d = total[31:0];
        st_d = F_OUT;
      end
      F_OUT: begin
        if (job_ready_i) st_d = F_IDLE;
      end
      default: st_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= F_IDLE;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    if (st_q == F_IDLE && in_valid_i) begin
      pc_q <= in_item_i.pulse_count;
      el_q <= in_item_i.elapsed_ms;
    end
    acc_q   <= acc_d;
    speed_q <= speed_d;
    flow_q  <= flow_d;
    cq_q    <= cq_d;
    rw_q    <= rw_d;
  end

  assign in_ready_o  = (st_q == F_IDLE);
  assign job_valid_o = (st_q == F_OUT);
  assign job_o.speed = speed_q;
  assign job_o.flow  = flow_q;

endmodule

// ===== rtl/sfv_queue.sv =====
// ----------------------------------------------------------------------------
// sfv_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module sfv_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  sfv_pkg::job_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output sfv_pkg::job_t rd_data_o
);

  sfv_pkg::job_t mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

// ===== rtl/sfv_back.sv =====
// ----------------------------------------------------------------------------
// sfv_back
// splits flow into valve counts and switches valves in rotation
// ----------------------------------------------------------------------------
module sfv_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfv_pkg::cfg_t      cfg_i,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  sfv_pkg::job_t      job_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sfv_pkg::out_item_t out_item_o
);

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001,
    B_HI   = 7'b0000010,
    B_LO   = 7'b0000100,
    B_RND  = 7'b0001000,
    B_MOD  = 7'b0010000,
    B_ADJ  = 7'b0100000,
    B_OUT  = 7'b1000000
  } bstate_e;

  bstate_e     st_q, st_d;
  logic [32:0] f_q, f_d;
  logic [3:0]  hi_q, hi_d;
  logic [2:0]  lo_q, lo_d;
  logic [3:0]  hcnt_q, hcnt_d, hptr_q, hptr_d, hid_q, hid_d, hn_q, hn_d;
  logic [2:0]  lcnt_q, lcnt_d, lptr_q, lptr_d, lid_q, lid_d, ln_q, ln_d;
  logic [3:0]  hcm_q, hcm_d;
  logic [2:0]  lcm_q, lcm_d;
  logic [3:0]  hstep_q, hstep_d;
  logic [2:0]  lstep_q, lstep_d;
  logic [15:0] map_q, map_d;
  logic        pump_q, pump_d, tog_q, tog_d;
  sfv_pkg::job_t job_q;
  logic [32:0] vh, vl;
  logic [3:0]  htot, hn_c;
  logic [2:0]  ltot, ln_c;
  logic [4:0]  hb;
  logic        hred, lred;
  logic [4:0]  hsum;
  logic [3:0]  lsum;

  assign vh   = 33'(cfg_i.high_valve_rate);
  assign vl   = 33'(cfg_i.low_valve_rate);
  assign htot = (cfg_i.high_valve_total == 4'd0) ? 4'd4 : cfg_i.high_valve_total;
  assign ltot = (cfg_i.low_valve_total == 3'd0) ? 3'd2 : cfg_i.low_valve_total;
  assign hn_c = (32'(htot) > 32'(sfv_pkg::HighMax)) ? 4'(sfv_pkg::HighMax) : htot;
  assign ln_c = (32'(ltot) > 32'(sfv_pkg::LowMax)) ? 3'(sfv_pkg::LowMax) : ltot;
  assign hb   = 5'(sfv_pkg::HighBankBase) + 5'(hid_q);

  // pointer or count still at or above the bank total
  assign hred = (hn_q != 4'd0) && (hid_q >= hn_q || hcm_q >= hn_q);
  assign lred = (ln_q != 3'd0) && (lid_q >= ln_q || lcm_q >= ln_q);
  assign hsum = 5'(hid_q) + 5'(hn_q) - 5'(hcm_q);
  assign lsum = 4'(lid_q) + 4'(ln_q) - 4'(lcm_q);

  always_comb begin
    st_d = st_q; f_d = f_q; hi_d = hi_q; lo_d = lo_q;
    hcnt_d = hcnt_q; hptr_d = hptr_q; hid_d = hid_q; hn_d = hn_q;
    lcnt_d = lcnt_q; lptr_d = lptr_q; lid_d = lid_q; ln_d = ln_q;
    hcm_d = hcm_q; lcm_d = lcm_q;
    hstep_d = hstep_q; lstep_d = lstep_q;
    map_d = map_q; pump_d = pump_q; tog_d = tog_q;
    case (st_q)
      B_IDLE: begin
        if (job_valid_i) begin
          f_d  = 33'(job_i.flow);
          hi_d = '0;
          lo_d = '0;
          hn_d = hn_c;
          ln_d = ln_c;
          st_d = (job_i.flow == 32'd0) ? B_RND : B_HI;
          if (job_i.flow == 32'd0) hstep_d = 4'hf; else hstep_d = '0;
        end
      end
      B_HI: begin
        if (f_q + (vh >> 2) >= vh && hi_q < hn_q) begin
          hi_d = hi_q + 4'd1;
          f_d  = (f_q > vh) ? f_q - vh : '0;
        end else st_d = B_LO;
      end
      B_LO: begin
        if (f_q >= vl && 4'(lo_q) < 4'(ln_q)) begin
          lo_d = lo_q + 3'd1;
          f_d  = f_q - vl;
        end else st_d = B_RND;
      end
      B_RND: begin
        // hstep all ones marks zero flow: no rounding
        if (hstep_q != 4'hf) begin
          if (f_q >= (vh >> 1) && hi_q < hn_q) hi_d = hi_q + 4'd1;
          else if (f_q >= (vl >> 1) && lo_q < ln_q) lo_d = lo_q + 3'd1;
        end
        // prepare both bank walks
        hid_d   = hptr_q;
        lid_d   = lptr_q;
        hcm_d   = hcnt_q;
        lcm_d   = lcnt_q;
        hstep_d = '0;
        lstep_d = '0;
        st_d    = B_MOD;
      end
      B_MOD: begin
        // reduce pointer and count modulo the bank total by repeated subtraction
        if (hn_q != 4'd0 && hid_q >= hn_q) hid_d = hid_q - hn_q;
        if (hn_q != 4'd0 && hcm_q >= hn_q) hcm_d = hcm_q - hn_q;
        if (ln_q != 3'd0 && lid_q >= ln_q) lid_d = lid_q - ln_q;
        if (ln_q != 3'd0 && lcm_q >= ln_q) lcm_d = lcm_q - ln_q;
        if (!hred && !lred) begin
          // closing starts at the oldest open valve
          if (hn_q != 4'd0 && hi_q < hcnt_q)
            hid_d = (hsum >= 5'(hn_q)) ? 4'(hsum - 5'(hn_q)) : hsum[3:0];
          if (ln_q != 3'd0 && lo_q < lcnt_q)
            lid_d = (lsum >= 4'(ln_q)) ? 3'(lsum - 4'(ln_q)) : lsum[2:0];
          st_d = B_ADJ;
        end
      end
      B_ADJ: begin
        // one high and one low valve per cycle
        if (hcnt_q != hi_q && hn_q != 4'd0 &&
            hstep_q != ((hi_q > hcnt_q) ? hi_q - hcnt_q : hcnt_q - hi_q)) begin
          if (hb < 5'(sfv_pkg::ValveBits)) map_d[hb[3:0]] = (hi_q > hcnt_q);
          hid_d   = (hid_q + 4'd1 >= hn_q) ? 4'd0 : hid_q + 4'd1;
          hstep_d = hstep_q + 4'd1;
        end
        if (lcnt_q != lo_q && ln_q != 3'd0 &&
            lstep_q != ((lo_q > lcnt_q) ? lo_q - lcnt_q : lcnt_q - lo_q)) begin
          map_d[lid_q] = (lo_q > lcnt_q);
          lid_d   = (4'(lid_q) + 4'd1 >= 4'(ln_q)) ? 3'd0 : lid_q + 3'd1;
          lstep_d = lstep_q + 3'd1;
        end
        if ((hcnt_q == hi_q || hn_q == 4'd0 ||
             hstep_d == ((hi_q > hcnt_q) ? hi_q - hcnt_q : hcnt_q - hi_q)) &&
            (lcnt_q == lo_q || ln_q == 3'd0 ||
             lstep_d == ((lo_q > lcnt_q) ? lo_q - lcnt_q : lcnt_q - lo_q))) begin
          if (hcnt_q != hi_q && hn_q != 4'd0 && hi_q > hcnt_q) hptr_d = hid_d;
          if (lcnt_q != lo_q && ln_q != 3'd0 && lo_q > lcnt_q) lptr_d = lid_d;
          hcnt_d = (hcnt_q != hi_q && hn_q == 4'd0) ? 4'd0 : hi_q;
          lcnt_d = (lcnt_q != lo_q && ln_q == 3'd0) ? 3'd0 : lo_q;
          pump_d = (hi_q != 4'd0) || (lo_q != 3'd0);
          tog_d  = pump_d != pump_q;
          st_d   = B_OUT;
        end
      end
      B_OUT: begin
        if (out_ready_i) st_d = B_IDLE;
      end
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_IDLE; hcnt_q <= '0; lcnt_q <= '0; hptr_q <= '0; lptr_q <= '0;
      map_q <= '0; pump_q <= 1'b0; tog_q <= 1'b0; hstep_q <= '0; lstep_q <= '0;
    end else begin
      st_q <= st_d; hcnt_q <= hcnt_d; lcnt_q <= lcnt_d; hptr_q <= hptr_d;
      lptr_q <= lptr_d; map_q <= map_d; pump_q <= pump_d; tog_q <= tog_d;
      hstep_q <= hstep_d; lstep_q <= lstep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == B_IDLE && job_valid_i) job_q <= job_i;
    f_q <= f_d; hi_q <= hi_d; lo_q <= lo_d; hid_q <= hid_d; lid_q <= lid_d;
    hn_q <= hn_d; ln_q <= ln_d; hcm_q <= hcm_d; lcm_q <= lcm_d;
  end

  assign job_ready_o = (st_q == B_IDLE);
  assign out_valid_o = (st_q == B_OUT);
  assign out_item_o.coverage_speed = job_q.speed;
  assign out_item_o.flow_demand    = job_q.flow;
  assign out_item_o.high_open      = hcnt_q;
  assign out_item_o.low_open       = lcnt_q;
  assign out_item_o.valve_map      = map_q;
  assign out_item_o.pump_running   = pump_q;
  assign out_item_o.pump_toggled   = tog_q;

endmodule

// ===== rtl/spray_flow_valve_controller_top.sv =====
// ----------------------------------------------------------------------------
// spray_flow_valve_controller_top
// flow demand and rotating valve control from wheel pulse periods
// ----------------------------------------------------------------------------
// channel   dir  handshake            payload
// in        in   in_valid_i/ready_o   sfv_pkg::in_item_t
// out       out  out_valid_o/ready_i  sfv_pkg::out_item_t
// apb       in   psel/penable         8 registers at 4*i
//
// auto items make two passes of the bit-serial divider by the period length
// in the front, between its control steps; dead-zone items make one pass,
// manual and short-period items none
// the back works in a flow split, a modulo pass and the valve walks
// a two-entry queue lets the front take the next item while the back works
// reset clears the valve map, counts, pointers and pump state
// ----------------------------------------------------------------------------
module spray_flow_valve_controller_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sfv_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sfv_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  sfv_pkg::cfg_t cfg_q;
  sfv_pkg::job_t fj, qj;
  logic fv, fr, qv, qr;
  sfv_pkg::reg_idx_e idx;

  assign idx    = sfv_pkg::reg_idx_e'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.boom_width_mm    <= 16'd5000;
      cfg_q.water_per_area   <= 16'd2000;
      cfg_q.high_valve_rate  <= 16'd10000;
      cfg_q.low_valve_rate   <= 16'd5000;
      cfg_q.high_valve_total <= 4'd4;
      cfg_q.low_valve_total  <= 3'd2;
      cfg_q.min_pulse_rate   <= 16'd1000;
      cfg_q.manual_rate      <= 32'd100000;
    end else if (psel && penable && pwrite) begin
      case (idx)
        sfv_pkg::REG_BOOM_WIDTH:  cfg_q.boom_width_mm    <= pwdata[15:0];
        sfv_pkg::REG_WATER_AREA:  cfg_q.water_per_area   <= pwdata[15:0];
        sfv_pkg::REG_HIGH_RATE:   cfg_q.high_valve_rate  <= pwdata[15:0];
        sfv_pkg::REG_LOW_RATE:    cfg_q.low_valve_rate   <= pwdata[15:0];
        sfv_pkg::REG_HIGH_TOTAL:  cfg_q.high_valve_total <= pwdata[3:0];
        sfv_pkg::REG_LOW_TOTAL:   cfg_q.low_valve_total  <= pwdata[2:0];
        sfv_pkg::REG_MIN_PULSE:   cfg_q.min_pulse_rate   <= pwdata[15:0];
        sfv_pkg::REG_MANUAL_RATE: cfg_q.manual_rate      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sfv_pkg::REG_BOOM_WIDTH:  prdata = 32'(cfg_q.boom_width_mm);
      sfv_pkg::REG_WATER_AREA:  prdata = 32'(cfg_q.water_per_area);
      sfv_pkg::REG_HIGH_RATE:   prdata = 32'(cfg_q.high_valve_rate);
      sfv_pkg::REG_LOW_RATE:    prdata = 32'(cfg_q.low_valve_rate);
      sfv_pkg::REG_HIGH_TOTAL:  prdata = 32'(cfg_q.high_valve_total);
      sfv_pkg::REG_LOW_TOTAL:   prdata = 32'(cfg_q.low_valve_total);
      sfv_pkg::REG_MIN_PULSE:   prdata = 32'(cfg_q.min_pulse_rate);
      sfv_pkg::REG_MANUAL_RATE: prdata = cfg_q.manual_rate;
      default:                  prdata = '0;
    endcase
  end

  sfv_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_i(cfg_q),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .job_valid_o(fv), .job_ready_i(fr), .job_o(fj)
  );

  sfv_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .wr_valid_i(fv), .wr_ready_o(fr), .wr_data_i(fj),
    .rd_valid_o(qv), .rd_ready_i(qr), .rd_data_o(qj)
  );

  sfv_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_i(cfg_q),
    .job_valid_i(qv), .job_ready_o(qr), .job_i(qj),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o)
  );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// checks the spray flow valve controller: items with random idling on both
// channels are predicted in a scoreboard and results compared field by field
// ----------------------------------------------------------------------------
module tb;

  class valve_scoreboard;
    sfv_pkg::cfg_t        cfg;
    logic [3:0]           hptr, hcnt;
    logic [2:0]           lptr, lcnt;
    logic [15:0]          vmap;
    logic                 pump;
    sfv_pkg::out_item_t   pending[$];
    int                   errors;

    function new();
      errors = 0;
      reset_state();
    endfunction

    function void reset_state();
      cfg.boom_width_mm = 5000;
      cfg.water_per_area = 2000;
      cfg.high_valve_rate = 10000;
      cfg.low_valve_rate = 5000;
      cfg.high_valve_total = 4;
      cfg.low_valve_total = 2;
      cfg.min_pulse_rate = 1000;
      cfg.manual_rate = 100000;
      hptr = 0; hcnt = 0; lptr = 0; lcnt = 0; vmap = 0; pump = 0;
    endfunction

    function void set_reg(sfv_pkg::reg_idx_e idx, logic [31:0] v);
      case (idx)
        sfv_pkg::REG_BOOM_WIDTH:  cfg.boom_width_mm = v[15:0];
        sfv_pkg::REG_WATER_AREA:  cfg.water_per_area = v[15:0];
        sfv_pkg::REG_HIGH_RATE:   cfg.high_valve_rate = v[15:0];
        sfv_pkg::REG_LOW_RATE:    cfg.low_valve_rate = v[15:0];
        sfv_pkg::REG_HIGH_TOTAL:  cfg.high_valve_total = v[3:0];
        sfv_pkg::REG_LOW_TOTAL:   cfg.low_valve_total = v[2:0];
        sfv_pkg::REG_MIN_PULSE:   cfg.min_pulse_rate = v[15:0];
        sfv_pkg::REG_MANUAL_RATE: cfg.manual_rate = v;
        default: ;
      endcase
    endfunction

    function longint unsigned area_speed(longint unsigned pc, longint unsigned el);
      longint unsigned dz, v;
      if (el < 100) return 0;
      dz = (cfg.min_pulse_rate != 0) ? cfg.min_pulse_rate : 1000;
      if (pc * 60000 / el < dz || pc == 0) return 0;
      v = (pc > 'hffff) ? 'hffff : pc;
      v = v * cfg.boom_width_mm / 10000;
      if (v > 'hffff) v = 'hffff;
      return v * 60000 / el;
    endfunction

    // returns new count; opens from the bank pointer, closes from the oldest open valve
    function int unsigned walk_bank(int unsigned cur, int unsigned tgt, int unsigned num,
                                    inout int unsigned ptr, input int unsigned base);
      int unsigned id, n;
      bit opening;
      if (cur == tgt) return cur;
      if (num == 0) return 0;
      id = ptr % num;
      if (tgt > cur) begin
        n = tgt - cur; opening = 1;
      end else begin
        n = cur - tgt; opening = 0;
        id = (id + num - (cur % num)) % num;
      end
      for (int unsigned i = 0; i < n; i++) begin
        if (base + id < sfv_pkg::ValveBits) vmap[base + id] = opening;
        id = (id + 1 >= num) ? 0 : id + 1;
      end
      if (opening) ptr = id;
      return tgt;
    endfunction

    function void note_item(sfv_pkg::in_item_t it);
      longint unsigned speed, flow, f, vh, vl;
      int unsigned hn, ln, hi, lo, hp, lp;
      logic newpump;
      sfv_pkg::out_item_t r;
      speed = 0; hi = 0; lo = 0;
      if (it.manual_mode) begin
        if (cfg.manual_rate == 0) flow = 100000;
        else if (cfg.manual_rate == 32'hffffffff) flow = 0;
        else flow = cfg.manual_rate;
      end else begin
        speed = area_speed(it.pulse_count, it.elapsed_ms);
        flow = speed * cfg.water_per_area / 100;
        if (flow > 64'hffffffff) flow = 64'hffffffff;
      end
      hn = (cfg.high_valve_total != 0) ? cfg.high_valve_total : 4;
      ln = (cfg.low_valve_total != 0) ? cfg.low_valve_total : 2;
      if (hn > sfv_pkg::HighMax) hn = sfv_pkg::HighMax;
      if (ln > sfv_pkg::LowMax) ln = sfv_pkg::LowMax;
      vh = cfg.high_valve_rate;
      vl = cfg.low_valve_rate;
      f = flow;
      if (f != 0) begin
        while (f + vh / 4 >= vh && hi < hn) begin
          hi++;
          f = (f > vh) ? f - vh : 0;
        end
        while (f >= vl && lo < ln) begin
          lo++;
          f -= vl;
        end
        if (f >= vh / 2 && hi < hn) hi++;
        else if (f >= vl / 2 && lo < ln) lo++;
      end
      hp = hptr; lp = lptr;
      hcnt = walk_bank(hcnt, hi, hn, hp, sfv_pkg::HighBankBase);
      lcnt = walk_bank(lcnt, lo, ln, lp, 0);
      hptr = hp[3:0]; lptr = lp[2:0];
      newpump = (hi + lo) != 0;
      r.coverage_speed = speed[25:0];
      r.flow_demand = flow[31:0];
      r.high_open = hcnt;
      r.low_open = lcnt;
      r.valve_map = vmap;
      r.pump_running = newpump;
      r.pump_toggled = newpump != pump;
      pump = newpump;
      pending.push_back(r);
    endfunction

    function void check_result(sfv_pkg::out_item_t got);
      sfv_pkg::out_item_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: speed %0d/%0d flow %0d/%0d high %0d/%0d low %0d/%0d",
                    " map %h/%h pump %b/%b tog %b/%b"},
                   exp.coverage_speed, got.coverage_speed, exp.flow_demand, got.flow_demand,
                   exp.high_open, got.high_open, exp.low_open, got.low_open,
                   exp.valve_map, got.valve_map, exp.pump_running, got.pump_running,
                   exp.pump_toggled, got.pump_toggled);
      end
    endfunction
  endclass

  logic               clk_i, rst_ni;
  logic               in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  sfv_pkg::in_item_t  in_item_i;
  sfv_pkg::out_item_t out_item_o;
  logic               psel, penable, pwrite, pready;
  logic [4:0]         paddr;
  logic [31:0]        pwdata, prdata;

  valve_scoreboard sb;
  int send_idle, recv_idle;

  spray_flow_valve_controller_top dut (.*);

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

  // receiver with random stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_item_o);
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic write_reg(sfv_pkg::reg_idx_e idx, logic [31:0] v);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(idx, v);
  endtask

  // valid drops only in an idle cycle, so items can follow back to back
  task automatic send_item(sfv_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(it);
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_valid_i <= 0;
    while (sb.pending.size() != 0 && n < 200000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (300) @(posedge clk_i);
  endtask

  function automatic logic [23:0] rnd24();
    case ($urandom_range(3))
      0: return 24'($urandom_range(24'hffffff));
      1: return 24'($urandom_range(2000));
      2: return 24'($urandom_range(200, 5000));
      default: return $urandom_range(0, 1) ? 24'hffffff : 24'd0;
    endcase
  endfunction

  task automatic mk_send(logic [23:0] pc, logic [23:0] el, logic man);
    sfv_pkg::in_item_t it;
    it.pulse_count = pc; it.elapsed_ms = el; it.manual_mode = man;
    send_item(it);
  endtask

  task automatic random_cfg(bit extreme);
    for (int i = 0; i < 8; i++) begin
      logic [31:0] v;
      v = $urandom;
      if (extreme) v = $urandom_range(0, 1) ? 32'hffffffff : 32'd0;
      else if (i == sfv_pkg::REG_HIGH_RATE || i == sfv_pkg::REG_LOW_RATE)
        v = $urandom_range(20000);
      else if (i == sfv_pkg::REG_WATER_AREA || i == sfv_pkg::REG_BOOM_WIDTH)
        v = $urandom_range(1, 65535);
      else if (i == sfv_pkg::REG_MIN_PULSE) v = $urandom_range(3000);
      else if (i == sfv_pkg::REG_MANUAL_RATE && $urandom_range(1)) v = $urandom_range(200000);
      write_reg(sfv_pkg::reg_idx_e'(i), v);
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 0; in_valid_i = 0; in_item_i = '0; out_ready_i = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    send_idle = 34; recv_idle = 52;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    repeat (40) @(posedge clk_i);
    // directed
    mk_send(0, 0, 0);
    mk_send(24'hffffff, 24'hffffff, 0);
    mk_send(24'hffffff, 100, 0);
    mk_send(5, 99, 0);
    mk_send(1, 100, 0);
    mk_send(2000, 1000, 0);
    mk_send(0, 500, 1);
    mk_send(0, 0, 0);
    drain();
    write_reg(sfv_pkg::REG_MANUAL_RATE, 0);
    mk_send(0, 0, 1);
    drain();
    write_reg(sfv_pkg::REG_MANUAL_RATE, 32'hffffffff);
    mk_send(0, 0, 1);
    drain();
    write_reg(sfv_pkg::REG_MIN_PULSE, 0);
    write_reg(sfv_pkg::REG_HIGH_TOTAL, 0);
    write_reg(sfv_pkg::REG_LOW_TOTAL, 0);
    write_reg(sfv_pkg::REG_MANUAL_RATE, 32'hfffffffe);
    mk_send(3000, 1000, 0);
    mk_send(1, 1, 1);
    drain();
    write_reg(sfv_pkg::REG_HIGH_TOTAL, 15);
    write_reg(sfv_pkg::REG_LOW_TOTAL, 7);
    write_reg(sfv_pkg::REG_HIGH_RATE, 0);
    write_reg(sfv_pkg::REG_LOW_RATE, 0);
    mk_send(1, 1, 1);
    mk_send(0, 0, 0);
    drain();
    write_reg(sfv_pkg::REG_HIGH_TOTAL, 2);
    write_reg(sfv_pkg::REG_LOW_TOTAL, 1);
    mk_send(1, 1, 1);
    mk_send(0, 0, 0);
    drain();
    write_reg(sfv_pkg::REG_BOOM_WIDTH, 65535);
    write_reg(sfv_pkg::REG_WATER_AREA, 65535);
    write_reg(sfv_pkg::REG_HIGH_RATE, 65535);
    write_reg(sfv_pkg::REG_LOW_RATE, 1);
    write_reg(sfv_pkg::REG_MIN_PULSE, 65535);
    mk_send(24'hffffff, 100, 0);
    mk_send(65535, 100, 0);
    drain();
    // random phases
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_idle = 52; recv_idle = 34;
      end else if (ph == 8) begin
        send_idle = 0; recv_idle = 0;
      end
      random_cfg(ph == 3 || ph == 10);
      for (int k = 0; k < 140; k++)
        mk_send(rnd24(), rnd24(), $urandom_range(3) == 0);
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/sfv_pkg.sv
rtl/sfv_div.sv
rtl/sfv_front.sv
rtl/sfv_queue.sv
rtl/sfv_back.sv
rtl/spray_flow_valve_controller_top.sv
tb/tb.sv
